// ===== rtl/lfpd_pkg.sv =====
package lfpd_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SENSOR_W    = 8;
	localparam int ERR_W       = 13;
	localparam int DIFF_W      = ERR_W + 1;
	localparam int INTEG_W     = 16;
	localparam int CORR_W      = 16;
	localparam int GAIN_W      = 24;
	localparam int SPEED_W     = 10;
	localparam int DRIVE_W     = 2;
	localparam int REG_COUNT   = 8;
	localparam int REG_IDX_W   = $clog2(REG_COUNT);
	localparam int CFG_DATA_W  = GAIN_W;
	localparam int PROD_P_W    = ERR_W + GAIN_W + 1;
	localparam int PROD_I_W    = INTEG_W + GAIN_W + 1;
	localparam int PROD_D_W    = DIFF_W + GAIN_W + 1;
	localparam int SUM_W       = PROD_I_W + 2;
	localparam int MOTOR_W     = CORR_W + 2;
	localparam int PAT_COUNT   = 22;
	localparam int SPIN_STEPS  = 7;

	localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd6553600;
	localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd52;
	localparam logic [GAIN_W-1:0]  KD_RESET    = 24'd39322;
	localparam logic [SPEED_W-1:0] BASE_RESET  = 10'd800;
	localparam logic [SPEED_W-1:0] MAX_RESET   = 10'd1000;
	localparam logic [SPEED_W-1:0] DEAD_RESET  = 10'd30;
	localparam logic [SPEED_W-1:0] NUDGE_RESET = 10'd800;
	localparam logic [SPEED_W-1:0] TURN_RESET  = 10'd1000;

	localparam logic signed [ERR_W-1:0] NUDGE_ERR = 13'sd50;
	localparam logic signed [ERR_W-1:0] SPIN_STEP = 13'sd100;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KP    = 3'd0,
		REG_KI    = 3'd1,
		REG_KD    = 3'd2,
		REG_BASE  = 3'd3,
		REG_MAX   = 3'd4,
		REG_DEAD  = 3'd5,
		REG_NUDGE = 3'd6,
		REG_TURN  = 3'd7
	} reg_idx_t;

	typedef enum logic [DRIVE_W-1:0] {
		DRIVE_FWD    = 2'd0,
		DRIVE_SPIN_A = 2'd1,
		DRIVE_SPIN_B = 2'd2
	} drive_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  ki;
		logic [GAIN_W-1:0]  kd;
		logic [SPEED_W-1:0] base_speed;
		logic [SPEED_W-1:0] max_speed;
		logic [SPEED_W-1:0] dead_speed;
		logic [SPEED_W-1:0] nudge_speed;
		logic [SPEED_W-1:0] turn_speed;
	} cfg_t;

	// one tracked sample, ready for the pid arithmetic
	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DIFF_W-1:0]  diff;
		logic                      is_pid;
		drive_t                    drive;
		logic                      hold;
		logic [SPEED_W-1:0]        fixed_speed;
	} trk_t;

	typedef struct packed {
		logic                    hit;
		logic signed [ERR_W-1:0] err;
	} pat_hit_t;

	localparam logic [SENSOR_W-1:0] PAT_MASK [PAT_COUNT] = '{
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h07, 8'hE0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	localparam logic [SENSOR_W-1:0] PAT_VALUE [PAT_COUNT] = '{
		8'hE7, 8'hF7, 8'hEF, 8'hFB, 8'hDF, 8'hFD, 8'hBF, 8'hFE, 8'h7F, 8'hFC, 8'h3F,
		8'h00, 8'h00, 8'hF0, 8'h0F, 8'hE0, 8'h07, 8'hE1, 8'h87, 8'hE3, 8'hC7, 8'hFF
	};

	localparam logic signed [ERR_W-1:0] PAT_ERR [PAT_COUNT] = '{
		13'sd0, 13'sd1, -13'sd1, 13'sd2, -13'sd2, 13'sd50, -13'sd50,
		13'sd100, -13'sd100, 13'sd200, -13'sd200, 13'sd300, -13'sd300,
		13'sd400, -13'sd400, 13'sd500, -13'sd500, 13'sd600, -13'sd600,
		13'sd700, -13'sd700, 13'sd4000
	};

	// first matching entry wins
	function automatic pat_hit_t pattern_lookup(input logic [SENSOR_W-1:0] s);
		pat_hit_t r;
		r.hit = 1'b0;
		r.err = '0;
		for (int i = PAT_COUNT - 1; i >= 0; i--) begin
			if ((s & PAT_MASK[i]) == PAT_VALUE[i]) begin
				r.hit = 1'b1;
				r.err = PAT_ERR[i];
			end
		end
		return r;
	endfunction

	// true for +100, +200 .. +700
	function automatic logic is_spin_pos(input logic signed [ERR_W-1:0] e);
		logic r;
		r = 1'b0;
		for (int k = 1; k <= SPIN_STEPS; k++) begin
			if (e == ERR_W'(k) * SPIN_STEP)
				r = 1'b1;
		end
		return r;
	endfunction

	function automatic logic signed [INTEG_W-1:0] sat_integ(
		input logic signed [INTEG_W:0] v
	);
		logic signed [INTEG_W-1:0] r;
		if (v[INTEG_W] != v[INTEG_W-1])
			r = v[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			r = v[INTEG_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/lfpd_in_if.sv =====
interface lfpd_in_if;
	import lfpd_pkg::*;

	logic                valid;
	logic                ready;
	logic [SENSOR_W-1:0] sensors;

	modport source (output valid, output sensors, input ready);
	modport sink (input valid, input sensors, output ready);

endinterface

// ===== rtl/lfpd_out_if.sv =====
interface lfpd_out_if;
	import lfpd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [DRIVE_W-1:0]      drive;
	logic [SPEED_W-1:0]      speed_a;
	logic [SPEED_W-1:0]      speed_b;
	logic                    hold_turn;
	logic signed [ERR_W-1:0] line_error;

	modport source (
		output valid, output drive, output speed_a, output speed_b,
		output hold_turn, output line_error, input ready
	);
	modport sink (
		input valid, input drive, input speed_a, input speed_b,
		input hold_turn, input line_error, output ready
	);

endinterface

// ===== rtl/lfpd_cfg.sv =====
module lfpd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lfpd_pkg::cfg_t                   cfg
);
	import lfpd_pkg::*;

	cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp          <= KP_RESET;
			regs_q.ki          <= KI_RESET;
			regs_q.kd          <= KD_RESET;
			regs_q.base_speed  <= BASE_RESET;
			regs_q.max_speed   <= MAX_RESET;
			regs_q.dead_speed  <= DEAD_RESET;
			regs_q.nudge_speed <= NUDGE_RESET;
			regs_q.turn_speed  <= TURN_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_KP:    regs_q.kp          <= cfg_data[GAIN_W-1:0];
				REG_KI:    regs_q.ki          <= cfg_data[GAIN_W-1:0];
				REG_KD:    regs_q.kd          <= cfg_data[GAIN_W-1:0];
				REG_BASE:  regs_q.base_speed  <= cfg_data[SPEED_W-1:0];
				REG_MAX:   regs_q.max_speed   <= cfg_data[SPEED_W-1:0];
				REG_DEAD:  regs_q.dead_speed  <= cfg_data[SPEED_W-1:0];
				REG_NUDGE: regs_q.nudge_speed <= cfg_data[SPEED_W-1:0];
				REG_TURN:  regs_q.turn_speed  <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== rtl/lfpd_track.sv =====
module lfpd_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [lfpd_pkg::SENSOR_W-1:0] sensors,
	input  lfpd_pkg::cfg_t                cfg,
	output lfpd_pkg::trk_t                item
);
	import lfpd_pkg::*;

	logic signed [ERR_W-1:0]   held_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;

	pat_hit_t                  hit;
	logic signed [ERR_W-1:0]   err;
	logic signed [INTEG_W-1:0] integ_new;
	logic                      nudge_a;
	logic                      nudge_b;
	logic                      spin_a;
	logic                      spin_b;
	logic                      is_pid;

	always_comb begin
		hit       = pattern_lookup(sensors);
		err       = hit.hit ? hit.err : held_q;
		integ_new = sat_integ((INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(err));
		nudge_a   = (err == NUDGE_ERR);
		nudge_b   = (err == -NUDGE_ERR);
		spin_a    = is_spin_pos(err);
		spin_b    = is_spin_pos(-err);
		is_pid    = !(nudge_a || nudge_b || spin_a || spin_b);

		item.err         = err;
		item.integ       = integ_new;
		item.diff        = DIFF_W'(err) - DIFF_W'(prev_q);
		item.is_pid      = is_pid;
		item.hold        = spin_a || spin_b;
		item.fixed_speed = (nudge_a || nudge_b) ? cfg.nudge_speed : cfg.turn_speed;
		if (nudge_a || spin_a)
			item.drive = DRIVE_SPIN_A;
		else if (nudge_b || spin_b)
			item.drive = DRIVE_SPIN_B;
		else
			item.drive = DRIVE_FWD;
	end

	// loop state moves only on a transfer; a turn or a nudge leaves the pid memory alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			integ_q <= '0;
			prev_q  <= '0;
		end else if (take) begin
			held_q <= err;
			if (is_pid) begin
				integ_q <= integ_new;
				prev_q  <= err;
			end
		end
	end

endmodule

// ===== rtl/lfpd_pid.sv =====
module lfpd_pid (
	input  logic            clk,
	input  logic            arst_n,
	input  lfpd_pkg::cfg_t  cfg,
	input  logic            take,
	input  lfpd_pkg::trk_t  item,
	output logic            in_ready,
	lfpd_out_if.source      result
);
	import lfpd_pkg::*;

	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic                    is_pid;
		drive_t                  drive;
		logic                    hold;
		logic [SPEED_W-1:0]      fixed_speed;
	} ctl_t;

	localparam logic signed [SUM_W-1:0] CORR_MAX = SUM_W'((1 << (CORR_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] CORR_MIN = -SUM_W'(1 << (CORR_W - 1));

	logic                       v_s1, v_s2, v_s3, v_o_q;
	logic                       en_s2, en_s3, en_o;
	trk_t                       item_s1;
	ctl_t                       ctl_s2, ctl_s3;
	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_I_W-1:0] prod_i_s2;
	logic signed [PROD_D_W-1:0] prod_d_s2;
	logic signed [CORR_W-1:0]   corr_s3;

	logic signed [SUM_W-1:0]    sum;
	logic signed [SUM_W-1:0]    quot;
	logic signed [CORR_W-1:0]   corr;
	logic signed [MOTOR_W-1:0]  mot_a;
	logic signed [MOTOR_W-1:0]  mot_b;

	logic [DRIVE_W-1:0]         drive_q;
	logic [SPEED_W-1:0]         speed_a_q;
	logic [SPEED_W-1:0]         speed_b_q;
	logic                       hold_q;
	logic signed [ERR_W-1:0]    err_q;

	function automatic logic [SPEED_W-1:0] motor_clamp(
		input logic signed [MOTOR_W-1:0] v,
		input logic [SPEED_W-1:0]        max_s,
		input logic [SPEED_W-1:0]        dead_s
	);
		logic signed [MOTOR_W-1:0] c;
		c = v;
		if (c > $signed(MOTOR_W'(max_s)))
			c = $signed(MOTOR_W'(max_s));
		if (c < $signed(MOTOR_W'(dead_s)))
			c = '0;
		return c[SPEED_W-1:0];
	endfunction

	// each stage moves on when the one after it is empty or moving
	assign en_o     = !v_o_q || result.ready;
	assign en_s3    = !v_s3 || en_o;
	assign en_s2    = !v_s2 || en_s3;
	assign in_ready = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_o_q <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= take;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
			if (en_o)
				v_o_q <= v_s3;
		end
	end

	// stage 1: tracked sample
	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item;
	end

	// stage 2: three gain products side by side
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			prod_p_s2          <= PROD_P_W'(item_s1.err)
				* PROD_P_W'($signed({1'b0, cfg.kp}));
			prod_i_s2          <= PROD_I_W'(item_s1.integ)
				* PROD_I_W'($signed({1'b0, cfg.ki}));
			prod_d_s2          <= PROD_D_W'(item_s1.diff)
				* PROD_D_W'($signed({1'b0, cfg.kd}));
			ctl_s2.err         <= item_s1.err;
			ctl_s2.is_pid      <= item_s1.is_pid;
			ctl_s2.drive       <= item_s1.drive;
			ctl_s2.hold        <= item_s1.hold;
			ctl_s2.fixed_speed <= item_s1.fixed_speed;
		end
	end

	// stage 3: sum, scale with truncation toward zero, saturate
	always_comb begin
		sum  = SUM_W'(prod_p_s2) + SUM_W'(prod_i_s2) + SUM_W'(prod_d_s2);
		quot = (sum >>> FRAC_BITS)
			+ $signed(SUM_W'(sum[SUM_W-1] && (|sum[FRAC_BITS-1:0])));
		if (quot > CORR_MAX)
			corr = CORR_MAX[CORR_W-1:0];
		else if (quot < CORR_MIN)
			corr = CORR_MIN[CORR_W-1:0];
		else
			corr = quot[CORR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			corr_s3 <= corr;
			ctl_s3  <= ctl_s2;
		end
	end

	// output register: motor speeds
	always_comb begin
		mot_a = $signed(MOTOR_W'(cfg.base_speed)) + MOTOR_W'(corr_s3);
		mot_b = $signed(MOTOR_W'(cfg.base_speed)) - MOTOR_W'(corr_s3);
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			drive_q <= ctl_s3.drive;
			hold_q  <= ctl_s3.hold;
			err_q   <= ctl_s3.err;
			if (ctl_s3.is_pid) begin
				speed_a_q <= motor_clamp(mot_a, cfg.max_speed, cfg.dead_speed);
				speed_b_q <= motor_clamp(mot_b, cfg.max_speed, cfg.dead_speed);
			end else begin
				speed_a_q <= ctl_s3.fixed_speed;
				speed_b_q <= ctl_s3.fixed_speed;
			end
		end
	end

	assign result.valid      = v_o_q;
	assign result.drive      = drive_q;
	assign result.speed_a    = speed_a_q;
	assign result.speed_b    = speed_b_q;
	assign result.hold_turn  = hold_q;
	assign result.line_error = err_q;

endmodule

// ===== rtl/line_follower_pid_drive.sv =====
// port      kind         payload
// sample    sink         sensors[7:0]
// result    source       drive, speed_a, speed_b, hold_turn, line_error
// cfg_*     write only   cfg_we, cfg_index[2:0], cfg_data[23:0]
//
// one sample per clock while the result side keeps taking results
// line error and pid memory update at the sample transfer, the gain products,
// scaling and motor clamps follow in three more register stages
// each stage holds under a stall only if the stage after it is full
// reset clears the loop state, the stage valids and loads the default gains and speeds
module line_follower_pid_drive (
	input  logic                             clk,
	input  logic                             arst_n,
	lfpd_in_if.sink                          sample,
	lfpd_out_if.source                       result,
	input  logic                             cfg_we,
	input  logic [lfpd_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lfpd_pkg::*;

	cfg_t cfg;
	trk_t item;
	logic in_ready;
	logic take;

	assign sample.ready = in_ready;
	assign take         = sample.valid && in_ready;

	lfpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfpd_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.sensors (sample.sensors),
		.cfg     (cfg),
		.item    (item)
	);

	lfpd_pid u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.take     (take),
		.item     (item),
		.in_ready (in_ready),
		.result   (result)
	);

endmodule
